@@ rtl/core/idcb_pkg.sv @@
// Package with shared types and constants for the inverse distance color blend.
package idcb_pkg;

    localparam int unsigned CoordWidth = 16;
    localparam int unsigned ColorWidth = 32;
    localparam int unsigned DistWidth  = 33;
    localparam int unsigned WeightWidth = 49;
    localparam int unsigned AccWidth   = 61;
    localparam int unsigned NumWidth   = 64;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_SHADE = 1'b1
    } t_cmd;

    localparam logic [0:0] RegPointCount = 1'b0;

    typedef struct packed {
        logic                 start;
        logic [NumWidth-1:0]  dividend;
        logic [NumWidth-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [NumWidth-1:0]  quotient;
    } t_div_rsp;

endpackage

@@ rtl/core/idcb_divider.sv @@
// Restoring radix-2 divider that produces one quotient bit per cycle.
module idcb_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  idcb_pkg::t_div_req i_req,
    output idcb_pkg::t_div_rsp o_rsp
);
    import idcb_pkg::*;

    logic [NumWidth-1:0] r_num, n_num;
    logic [NumWidth-1:0] r_den;
    logic [NumWidth:0]   r_rem, n_rem;
    logic [6:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [NumWidth:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[NumWidth-1:0], r_num[NumWidth-1]};
        n_num   = {r_num[NumWidth-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_num[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(NumWidth);
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule

@@ rtl/core/inverse_distance_color_blend.sv @@
// Top level of the inverse distance color blend with point tables and sequencer.
// A write item stores one point in the tables. A shade item with n points in use is accepted,
// then the reciprocal weight of each point is found, then four channel passes run, and the
// result is loaded; all divisions go to the one shared bit-serial divider. A hit at zero distance
// returns early. The input stays blocked while a result waits to be taken. The point
// tables are small register memories.
module inverse_distance_color_blend #(
    parameter int unsigned MAX_POINTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: point_index[3:0], point_x[19:4], point_y[35:20], point_red[43:36],
    // point_green[51:44], point_blue[59:52], point_alpha[67:60],
    // pixel_x[83:68], pixel_y[99:84], zero pad [103:100]
    input  logic [103:0] s_axis_tdata,
    // tuser: command[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [31:0]  m_axis_tdata,
    // tuser: status[0]
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import idcb_pkg::*;

    localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_DIST  = 8'b0000_0100,
        S_WDIV  = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_CDIV  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_WRITE = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic [CoordWidth-1:0] r_xmem [MAX_POINTS];
    logic [CoordWidth-1:0] r_ymem [MAX_POINTS];
    logic [ColorWidth-1:0] r_cmem [MAX_POINTS];
    logic [WeightWidth-1:0] r_wmem [MAX_POINTS];

    logic [4:0]            r_point_count;
    logic [103:0]          r_item;
    logic [IdxW-1:0]       r_idx;
    logic [CntW-1:0]       r_n;
    logic [1:0]            r_ch;
    logic                  r_pass;
    logic [CoordWidth-1:0] r_rx, r_ry;
    logic [ColorWidth-1:0] r_rc;
    logic [WeightWidth-1:0] r_rw;
    logic [NumWidth-1:0]   r_wsum;
    logic [AccWidth-1:0]   r_acc;
    logic [31:0]           r_out;
    logic                  r_status;
    logic                  r_ovalid;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [CoordWidth-1:0] w_px, w_py, w_dx, w_dy;
    logic [2*CoordWidth-1:0] w_dx2, w_dy2;
    logic [DistWidth-1:0]  w_dist;
    logic [WeightWidth+7:0] w_prod;
    logic [7:0]            w_chan;
    logic                  w_last;
    logic [CntW-1:0]       w_cnt_sat;
    logic [IdxW-1:0]       w_wr_idx;

    idcb_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign w_px = r_item[83:68];
    assign w_py = r_item[99:84];
    assign w_dx = (w_px >= r_rx) ? (w_px - r_rx) : (r_rx - w_px);
    assign w_dy = (w_py >= r_ry) ? (w_py - r_ry) : (r_ry - w_py);
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_dist = {1'b0, w_dx2} + {1'b0, w_dy2};
    assign w_chan = r_rc[8*r_ch +: 8];
    assign w_prod = r_rw * w_chan;
    assign w_last = (CntW'(r_idx) == (r_n - CntW'(1)));
    assign w_cnt_sat = (32'(r_point_count) > MAX_POINTS) ? CntW'(MAX_POINTS)
                                                         : CntW'(r_point_count);
    assign w_wr_idx = IdxW'(r_item[3:0]);

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = {15'd0, 1'b1, 48'd0};
        w_req.divisor  = 64'(w_dist);
        if (r_state == S_DIST) begin
            w_req.start = (w_dist != '0);
        end else if (r_state == S_ACC && w_last && r_pass) begin
            w_req.start    = 1'b1;
            w_req.dividend = 64'(r_acc + AccWidth'(w_prod));
            w_req.divisor  = r_wsum;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_status;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == RegPointCount) ? {27'd0, r_point_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (psel && penable && pwrite && paddr[2] == RegPointCount) begin
            r_point_count <= pwdata[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx <= r_xmem[r_idx];
        r_ry <= r_ymem[r_idx];
        r_rc <= r_cmem[r_idx];
        r_rw <= r_wmem[r_idx];
        if (r_state == S_WRITE && 32'(r_item[3:0]) < MAX_POINTS) begin
            r_xmem[w_wr_idx] <= r_item[19:4];
            r_ymem[w_wr_idx] <= r_item[35:20];
            r_cmem[w_wr_idx] <= r_item[67:36];
        end
        if (r_state == S_WDIV && w_rsp.done) begin
            r_wmem[r_idx] <= w_rsp.quotient[WeightWidth-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_item <= s_axis_tdata;
                        r_idx  <= '0;
                        r_wsum <= '0;
                        r_pass <= 1'b0;
                        r_n    <= w_cnt_sat;
                        if (s_axis_tuser[0] == CMD_WRITE) begin
                            r_state <= S_WRITE;
                        end else if (w_cnt_sat == '0) begin
                            r_out    <= '0;
                            r_status <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_RD: begin
                    r_state <= r_pass ? S_ACC : S_DIST;
                end
                S_DIST: begin
                    if (w_dist == '0) begin
                        r_out    <= r_rc;
                        r_status <= 1'b0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (w_rsp.done) begin
                        r_wsum <= r_wsum + w_rsp.quotient;
                        if (w_last) begin
                            r_pass <= 1'b1;
                            r_idx  <= '0;
                            r_ch   <= '0;
                            r_acc  <= '0;
                        end else begin
                            r_idx <= r_idx + IdxW'(1);
                        end
                        r_state <= S_RD;
                    end
                end
                S_ACC: begin
                    r_acc <= r_acc + AccWidth'(w_prod);
                    if (w_last) begin
                        r_state <= S_CDIV;
                    end else begin
                        r_idx   <= r_idx + IdxW'(1);
                        r_state <= S_RD;
                    end
                end
                S_CDIV: begin
                    if (w_rsp.done) begin
                        r_out[8*r_ch +: 8] <= (w_rsp.quotient > 64'd255) ? 8'hFF
                                              : w_rsp.quotient[7:0];
                        r_acc <= '0;
                        r_idx <= '0;
                        if (r_ch == 2'd3) begin
                            r_status <= 1'b0;
                            r_state  <= S_OUT;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
